### rtl/clex_pkg.sv
// Package for the character LCD expander nibble writer.
// Holds item modes, hold times, text byte codes and the glyph mapping.
// No dependencies.
package clex_pkg;

    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_TEXT = 2'd2;

    localparam logic [8:0] HOLD_SETUP = 9'd500;
    localparam logic [8:0] HOLD_LONG  = 9'd40;
    localparam logic [8:0] HOLD_SHORT = 9'd37;

    localparam logic [2:0] STEP_SETUP     = 3'd0;
    localparam logic [2:0] STEP_FIRST_RS  = 3'd1;
    localparam logic [2:0] STEP_CMD_LAST  = 3'd2;
    localparam logic [2:0] STEP_DATA_LAST = 3'd6;

    localparam logic [7:0] TXT_LEAD_C3 = 8'd195;
    localparam logic [7:0] TXT_LEAD_C4 = 8'd196;
    localparam logic [7:0] TXT_LEAD_C5 = 8'd197;
    localparam logic [7:0] TXT_B6      = 8'd182;
    localparam logic [7:0] TXT_96      = 8'd150;
    localparam logic [7:0] TXT_9C      = 8'd156;
    localparam logic [7:0] TXT_BC      = 8'd188;
    localparam logic [7:0] TXT_87      = 8'd135;
    localparam logic [7:0] TXT_A7      = 8'd167;
    localparam logic [7:0] TXT_9E      = 8'd158;
    localparam logic [7:0] TXT_9F      = 8'd159;
    localparam logic [7:0] TXT_B0      = 8'd176;
    localparam logic [7:0] TXT_B1      = 8'd177;

    localparam logic [7:0] GLYPH_O_UML = 8'd239;
    localparam logic [7:0] GLYPH_U_UML = 8'd245;
    localparam logic [7:0] GLYPH_C_CED = 8'd0;
    localparam logic [7:0] GLYPH_G_BRV = 8'd1;
    localparam logic [7:0] GLYPH_S_CED = 8'd2;
    localparam logic [7:0] GLYPH_G_BRV_L = 8'd3;
    localparam logic [7:0] GLYPH_I_DOT = 8'd4;
    localparam logic [7:0] GLYPH_I_DLS = 8'd5;

    typedef struct packed {
        logic       send;
        logic [7:0] glyph;
        logic       c4;
        logic       c5;
    } t_map;

    function automatic t_map map_text(input logic [7:0] v, input logic c4,
                                      input logic c5);
        t_map m;
        m.send  = 1'b1;
        m.glyph = v;
        m.c4    = c4;
        m.c5    = c5;
        case (v) inside
            TXT_LEAD_C3: m.send = 1'b0;
            TXT_B6, TXT_96: m.glyph = GLYPH_O_UML;
            TXT_9C, TXT_BC: m.glyph = GLYPH_U_UML;
            TXT_87, TXT_A7: m.glyph = GLYPH_C_CED;
            TXT_LEAD_C4: begin
                m.send = 1'b0;
                m.c4   = 1'b1;
            end
            TXT_LEAD_C5: begin
                m.send = 1'b0;
                m.c5   = 1'b1;
            end
            TXT_9E, TXT_9F: begin
                if (c4) begin
                    m.c4    = 1'b0;
                    m.glyph = (v == TXT_9E) ? GLYPH_G_BRV : GLYPH_G_BRV_L;
                end else if (c5) begin
                    m.c5    = 1'b0;
                    m.glyph = GLYPH_S_CED;
                end else begin
                    m.send = 1'b0;
                end
            end
            TXT_B0, TXT_B1: begin
                if (c4) begin
                    m.c4    = 1'b0;
                    m.glyph = (v == TXT_B0) ? GLYPH_I_DOT : GLYPH_I_DLS;
                end else begin
                    m.send = 1'b0;
                end
            end
            default: ;
        endcase
        return m;
    endfunction

endpackage

### rtl/char_lcd_expander_nibble_writer.sv
// Character LCD expander nibble writer, top level.
// Turns command, data and text requests into expander byte sequences.
// Depends on clex_pkg.

// Each accepted request is decoded into a job register, and the job then
// issues one expander byte per cycle into the output register while the
// receiver does not stall: a command takes 3 bytes, a data or text byte 6,
// or 7 when the display is switched from command to data mode (setup byte
// first). A text byte that is dropped, and mode 3, give no output. The next
// request is taken in the cycle the current job hands over its final byte.
// Backlight is applied to every byte and must only be written while the
// block is idle.
module char_lcd_expander_nibble_writer
    import clex_pkg::*;
#(
    parameter int ENABLE_MASK = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_backlight_on,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_expander_byte,
    output logic [8:0] o_hold_us,
    output logic       o_last
);

    localparam logic [7:0] EnMask = 8'(ENABLE_MASK);

    logic       r_backlight;
    logic       r_rs_is_data, n_rs_is_data;
    logic       r_lead_c4, n_lead_c4;
    logic       r_lead_c5, n_lead_c5;

    logic       r_job_vld, n_job_vld;
    logic       r_job_data, n_job_data;
    logic [3:0] r_nib_hi, n_nib_hi;
    logic [3:0] r_nib_lo, n_nib_lo;
    logic [2:0] r_step, n_step;

    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic [8:0] r_out_hold;
    logic       r_out_last;

    logic       out_load;
    logic       job_final;
    logic       in_accept;
    logic [7:0] byte_cur;
    logic [8:0] hold_cur;
    logic [7:0] hi_base;
    logic [7:0] hi_rs;
    logic [7:0] lo_rs;
    logic [7:0] send_byte;
    logic       send_ok;
    t_map       tmap;

    assign o_cfg_ready = 1'b1;

    assign out_load  = r_job_vld && (!r_out_vld || !i_out_stall);
    assign job_final = r_step == (r_job_data ? STEP_DATA_LAST : STEP_CMD_LAST);
    assign o_in_stall = r_job_vld && !(out_load && job_final);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Byte for the current step
    assign hi_base = {r_nib_hi, r_backlight, 3'b000};
    assign hi_rs   = hi_base | 8'h01;
    assign lo_rs   = {r_nib_lo, r_backlight, 3'b001};

    always_comb begin
        byte_cur = hi_base;
        hold_cur = HOLD_LONG;
        if (r_job_data) begin
            case (r_step)
                3'd0: begin
                    byte_cur = hi_base;
                    hold_cur = HOLD_SETUP;
                end
                3'd1: begin
                    byte_cur = hi_rs;
                    hold_cur = HOLD_SHORT;
                end
                3'd2: begin
                    byte_cur = hi_rs | EnMask;
                    hold_cur = HOLD_SHORT;
                end
                3'd3: begin
                    byte_cur = hi_rs & ~EnMask;
                    hold_cur = HOLD_SHORT;
                end
                3'd4: begin
                    byte_cur = lo_rs;
                    hold_cur = HOLD_LONG;
                end
                3'd5: begin
                    byte_cur = lo_rs | EnMask;
                    hold_cur = HOLD_LONG;
                end
                default: begin
                    byte_cur = lo_rs & ~EnMask;
                    hold_cur = HOLD_SHORT;
                end
            endcase
        end else begin
            case (r_step)
                3'd0: begin
                    byte_cur = hi_base;
                    hold_cur = HOLD_LONG;
                end
                3'd1: begin
                    byte_cur = hi_base | EnMask;
                    hold_cur = HOLD_LONG;
                end
                default: begin
                    byte_cur = hi_base & ~EnMask;
                    hold_cur = HOLD_SHORT;
                end
            endcase
        end
    end

    // Request decode
    always_comb begin
        tmap      = map_text(i_value, r_lead_c4, r_lead_c5);
        send_ok   = 1'b0;
        send_byte = i_value;
        case (i_mode)
            MODE_DATA: send_ok = 1'b1;
            MODE_TEXT: begin
                send_ok   = tmap.send;
                send_byte = tmap.glyph;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_rs_is_data = r_rs_is_data;
        n_lead_c4    = r_lead_c4;
        n_lead_c5    = r_lead_c5;
        n_job_vld    = r_job_vld;
        n_job_data   = r_job_data;
        n_nib_hi     = r_nib_hi;
        n_nib_lo     = r_nib_lo;
        n_step       = r_step;
        if (out_load) begin
            if (job_final) begin
                n_job_vld = 1'b0;
            end else begin
                n_step = r_step + 3'd1;
            end
        end
        if (in_accept) begin
            n_job_vld = 1'b0;
            if (i_mode == MODE_TEXT) begin
                n_lead_c4 = tmap.c4;
                n_lead_c5 = tmap.c5;
            end
            if (i_mode == MODE_CMD) begin
                n_job_vld    = 1'b1;
                n_job_data   = 1'b0;
                n_nib_hi     = i_value[3:0];
                n_step       = STEP_SETUP;
                n_rs_is_data = 1'b0;
            end else if (send_ok) begin
                n_job_vld    = 1'b1;
                n_job_data   = 1'b1;
                n_nib_hi     = send_byte[7:4];
                n_nib_lo     = send_byte[3:0];
                n_step       = r_rs_is_data ? STEP_FIRST_RS : STEP_SETUP;
                n_rs_is_data = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight  <= 1'b0;
            r_rs_is_data <= 1'b0;
            r_lead_c4    <= 1'b0;
            r_lead_c5    <= 1'b0;
            r_job_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_backlight <= i_cfg_backlight_on;
            end
            r_rs_is_data <= n_rs_is_data;
            r_lead_c4    <= n_lead_c4;
            r_lead_c5    <= n_lead_c5;
            r_job_vld    <= n_job_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_data <= n_job_data;
        r_nib_hi   <= n_nib_hi;
        r_nib_lo   <= n_nib_lo;
        r_step     <= n_step;
        if (out_load) begin
            r_out_byte <= byte_cur;
            r_out_hold <= hold_cur;
            r_out_last <= job_final;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_expander_byte = r_out_byte;
    assign o_hold_us       = r_out_hold;
    assign o_last          = r_out_last;

    // Command jobs never run past their third byte
    a_cmd_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_vld && !r_job_data |-> r_step <= STEP_CMD_LAST)
        else $error("command job step out of range");

    // A command request starts a fresh command job in command mode
    a_cmd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_mode == MODE_CMD |=>
            r_job_vld && !r_job_data && r_step == STEP_SETUP && !r_rs_is_data)
        else $error("command request did not start a command job");

    // A data job starting without setup means RS was already in data mode
    a_data_rs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_mode == MODE_DATA |=>
            r_job_vld && r_job_data && r_rs_is_data
            && (r_step == STEP_FIRST_RS) == $past(r_rs_is_data))
        else $error("data job start step disagrees with RS state");

endmodule

### bench/clex_stream_checker.sv
// Scoreboard for the character LCD expander nibble writer: watches the config,
// request and expander byte channels, predicts each byte and compares it.
// Depends on clex_pkg.
`timescale 1ns / 100ps
module clex_stream_checker
    import clex_pkg::*;
#(
    parameter int ENABLE_MASK = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_backlight_on,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_value,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_expander_byte,
    input  logic [8:0] i_hold_us,
    input  logic       i_last,
    output int         o_pending,
    output int         o_errors
);

    localparam logic [7:0] EN_BITS = 8'(ENABLE_MASK);
    localparam logic [7:0] RS_BIT  = 8'h01;
    localparam logic [7:0] BL_BIT  = 8'h08;
    localparam int         PRINT_CAP = 50;

    typedef struct packed {
        logic [7:0] xbyte;
        logic [8:0] hold;
        logic       last;
    } t_lcd_beat;

    t_lcd_beat pending_beats[$];
    logic      backlight;
    logic      rs_in_data;
    logic      seen_c4;
    logic      seen_c5;

    task automatic flag_mismatch(input string what);
        if (o_errors < PRINT_CAP)
            $display("%0t mismatch: %s", $time, what);
        o_errors++;
    endtask

    // plain byte, then enable raised, then enable dropped
    task automatic add_strobe(input logic [7:0] b, input logic [8:0] h_plain,
                              input logic [8:0] h_en);
        pending_beats.push_back('{b, h_plain, 1'b0});
        b = b | EN_BITS;
        pending_beats.push_back('{b, h_en, 1'b0});
        b = b & ~EN_BITS;
        pending_beats.push_back('{b, HOLD_SHORT, 1'b0});
    endtask

    task automatic predict_strobes(input logic [1:0] mode, input logic [7:0] value);
        logic [7:0] bl;
        logic [7:0] glyph;
        logic [7:0] hi;
        logic       send;
        int         start_size;
        start_size = pending_beats.size();
        bl     = backlight ? BL_BIT : 8'h00;
        glyph  = value;
        send   = 1'b0;
        case (mode)
            MODE_CMD: begin
                rs_in_data = 1'b0;
                add_strobe({value[3:0], 4'h0} | bl, HOLD_LONG, HOLD_LONG);
            end
            MODE_DATA: send = 1'b1;
            MODE_TEXT: begin
                send = 1'b1;
                case (value)
                    TXT_LEAD_C3: send = 1'b0;
                    TXT_B6, TXT_96: glyph = GLYPH_O_UML;
                    TXT_9C, TXT_BC: glyph = GLYPH_U_UML;
                    TXT_87, TXT_A7: glyph = GLYPH_C_CED;
                    TXT_LEAD_C4: begin
                        send    = 1'b0;
                        seen_c4 = 1'b1;
                    end
                    TXT_LEAD_C5: begin
                        send    = 1'b0;
                        seen_c5 = 1'b1;
                    end
                    TXT_9E, TXT_9F: begin
                        if (seen_c4) begin
                            seen_c4 = 1'b0;
                            glyph   = (value == TXT_9E) ? GLYPH_G_BRV : GLYPH_G_BRV_L;
                        end else if (seen_c5) begin
                            seen_c5 = 1'b0;
                            glyph   = GLYPH_S_CED;
                        end else begin
                            send = 1'b0;
                        end
                    end
                    TXT_B0, TXT_B1: begin
                        if (seen_c4) begin
                            seen_c4 = 1'b0;
                            glyph   = (value == TXT_B0) ? GLYPH_I_DOT : GLYPH_I_DLS;
                        end else begin
                            send = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (send) begin
            hi = {glyph[7:4], 4'h0} | bl;
            if (!rs_in_data) begin
                rs_in_data = 1'b1;
                pending_beats.push_back('{hi, HOLD_SETUP, 1'b0});
            end
            add_strobe(hi | RS_BIT, HOLD_SHORT, HOLD_SHORT);
            add_strobe({glyph[3:0], 4'h0} | bl | RS_BIT, HOLD_LONG, HOLD_LONG);
        end
        if (pending_beats.size() > start_size)
            pending_beats[pending_beats.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin : watch
        t_lcd_beat want;
        if (!i_rst_n) begin
            backlight  = 1'b0;
            rs_in_data = 1'b0;
            seen_c4    = 1'b0;
            seen_c5    = 1'b0;
            o_errors   = 0;
            pending_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_beats.size() == 0) begin
                    flag_mismatch($sformatf("byte %02h with nothing expected",
                                            i_expander_byte));
                end else begin
                    want = pending_beats.pop_front();
                    if (i_expander_byte !== want.xbyte)
                        flag_mismatch($sformatf("expander byte %02h, want %02h",
                                                i_expander_byte, want.xbyte));
                    if (i_hold_us !== want.hold)
                        flag_mismatch($sformatf("hold %0d us, want %0d us",
                                                i_hold_us, want.hold));
                    if (i_last !== want.last)
                        flag_mismatch($sformatf("last %b, want %b", i_last, want.last));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_strobes(i_mode, i_value);
            if (i_cfg_valid && i_cfg_ready)
                backlight = i_cfg_backlight_on;
        end
        o_pending = pending_beats.size();
    end

endmodule

### bench/char_lcd_expander_nibble_writer_tb.sv
// Testbench top for the character LCD expander nibble writer: drives config,
// requests and receiver stalls, and gives the verdict.
// Depends on clex_pkg, char_lcd_expander_nibble_writer and clex_stream_checker.
`timescale 1ns / 100ps
module char_lcd_expander_nibble_writer_tb;
    import clex_pkg::*;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         EN_MASK         = 4;
    localparam int         HOLDOFF_CYCLES  = 300;
    localparam int         QUIET_LIMIT     = 2000;
    localparam int         ITEMS_PER_PHASE = 16;
    localparam int         SETTLE_CYCLES   = 10;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       cfg_valid     = 1'b0;
    logic       cfg_backlight = 1'b0;
    logic       cfg_ready;
    logic       req_valid     = 1'b0;
    logic       req_stall;
    logic [1:0] req_mode      = MODE_CMD;
    logic [7:0] req_value     = 8'h00;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [7:0] out_byte;
    logic [8:0] out_hold;
    logic       out_last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_asked  = 0;
    int holdoff_left   = 0;
    int quiet_cycles   = 0;
    int beats_waiting;
    int errors;

    // UTF-8 sequences the text mapping knows
    logic [7:0] utf_lead [12] = '{TXT_LEAD_C3, TXT_LEAD_C3, TXT_LEAD_C3, TXT_LEAD_C3,
                                   TXT_LEAD_C3, TXT_LEAD_C3, TXT_LEAD_C4, TXT_LEAD_C4,
                                   TXT_LEAD_C4, TXT_LEAD_C4, TXT_LEAD_C5, TXT_LEAD_C5};
    logic [7:0] utf_tail [12] = '{TXT_B6, TXT_96, TXT_9C, TXT_BC, TXT_87, TXT_A7,
                                   TXT_9E, TXT_9F, TXT_B0, TXT_B1, TXT_9E, TXT_9F};

    logic [9:0] directed [28] = '{
        {MODE_CMD, 8'h00}, {MODE_CMD, 8'hFF}, {MODE_DATA, 8'h00}, {MODE_DATA, 8'hFF},
        {MODE_UNUSED, 8'hFF}, {MODE_CMD, 8'h03}, {MODE_TEXT, TXT_LEAD_C3},
        {MODE_TEXT, TXT_B6}, {MODE_TEXT, TXT_96}, {MODE_TEXT, TXT_9C},
        {MODE_TEXT, TXT_BC}, {MODE_TEXT, TXT_87}, {MODE_TEXT, TXT_A7},
        {MODE_TEXT, TXT_9E}, {MODE_TEXT, TXT_B0}, {MODE_TEXT, TXT_LEAD_C4},
        {MODE_TEXT, TXT_LEAD_C5}, {MODE_TEXT, TXT_9E}, {MODE_TEXT, TXT_9F},
        {MODE_TEXT, TXT_LEAD_C4}, {MODE_TEXT, TXT_9F}, {MODE_TEXT, TXT_LEAD_C4},
        {MODE_TEXT, TXT_B0}, {MODE_TEXT, TXT_LEAD_C4}, {MODE_TEXT, TXT_B1},
        {MODE_TEXT, TXT_LEAD_C5}, {MODE_TEXT, TXT_B0}, {MODE_TEXT, 8'h41}
    };

    char_lcd_expander_nibble_writer #(
        .ENABLE_MASK(EN_MASK)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_backlight_on(cfg_backlight),
        .i_in_valid        (req_valid),
        .o_in_stall        (req_stall),
        .i_mode            (req_mode),
        .i_value           (req_value),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_expander_byte   (out_byte),
        .o_hold_us         (out_hold),
        .o_last            (out_last)
    );

    clex_stream_checker #(
        .ENABLE_MASK(EN_MASK)
    ) scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_backlight_on(cfg_backlight),
        .i_in_valid        (req_valid),
        .i_in_stall        (req_stall),
        .i_mode            (req_mode),
        .i_value           (req_value),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_expander_byte   (out_byte),
        .i_hold_us         (out_hold),
        .i_last            (out_last),
        .o_pending         (beats_waiting),
        .o_errors          (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin : receiver
        int holdoff_seen;
        holdoff_seen = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_seen != holdoff_asked) begin
                holdoff_seen = holdoff_asked;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                out_stall <= 1'b1;
                holdoff_left--;
            end else begin
                out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_valid && !req_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic [1:0] m, input logic [7:0] v);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_mode  <= m;
        req_value <= v;
        do @(posedge i_clk); while (req_stall);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (beats_waiting != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_backlight(input logic on);
        drain();
        cfg_valid     <= 1'b1;
        cfg_backlight <= on;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // well-formed UTF-8 pairs, plus commands, raw bytes and noise
    task automatic push_random();
        int r;
        int k;
        r = $urandom_range(99);
        k = $urandom_range(11);
        if (r < 20) begin
            push_request(MODE_CMD, 8'($urandom_range(255)));
        end else if (r < 38) begin
            push_request(MODE_DATA, 8'($urandom_range(255)));
        end else if (r < 42) begin
            push_request(MODE_UNUSED, 8'($urandom_range(255)));
        end else if (r < 72) begin
            push_request(MODE_TEXT, utf_lead[k]);
            push_request(MODE_TEXT, utf_tail[k]);
        end else if (r < 82) begin
            push_request(MODE_TEXT, $urandom_range(1) ? utf_lead[k] : utf_tail[k]);
        end else begin
            push_request(MODE_TEXT, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_backlight(1'b0);
        foreach (directed[d])
            push_request(directed[d][9:8], directed[d][7:0]);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            write_backlight(phase % 2 == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 0 && n == 4)
                    holdoff_asked++;
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    drain();
                push_random();
            end
        end
        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
